// File: hdl/cbo_pkg.sv
// Shared types, widths and the saturation helper function of the camera basis orthonormaliser.
`timescale 1ns / 1ps
`default_nettype none
package cbo_pkg;

    localparam int CBO_FRAC_BITS = 14;
    localparam int CBO_COMP_W    = 16;
    localparam int CBO_RAW_W     = 33;
    localparam int CBO_MAG_W     = 32;
    localparam int CBO_NORM_W    = 30;
    localparam int CBO_SQ_W      = 2 * CBO_NORM_W;
    localparam int CBO_LEN_W     = CBO_SQ_W + 2;
    localparam int CBO_ROOT_W    = CBO_LEN_W / 2;
    localparam int CBO_POS_W     = 5;
    localparam int CBO_NORM_TOP  = CBO_NORM_W - 1;
    localparam int CBO_IN_W      = 6 * CBO_COMP_W;
    localparam int CBO_OUT_W     = 9 * CBO_COMP_W;

    typedef logic [2:0][CBO_COMP_W-1:0] t_vec3;
    typedef logic [2:0][CBO_RAW_W-1:0]  t_raw3;

    function automatic logic [CBO_COMP_W-1:0] cbo_sat16(input logic neg,
                                                        input logic [CBO_RAW_W-1:0] mag);
        logic [CBO_RAW_W-1:0] res;
        begin
            if (neg) begin
                if (mag > CBO_RAW_W'(32768)) begin
                    res = CBO_RAW_W'(32768);
                end else begin
                    res = mag;
                end
                res = -res;
            end else begin
                if (mag > CBO_RAW_W'(32767)) begin
                    res = CBO_RAW_W'(32767);
                end else begin
                    res = mag;
                end
            end
            return res[CBO_COMP_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/camera_basis_orthonormalize.sv
// Top level: forward and side normalisation, side and up cross products, output register.
// Throughput: one item per cycle while the result side does not stall; every stage is a
// register, led by the root and divider chains.
// A stall on the result side freezes the whole pipeline, and input is held off meanwhile.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module camera_basis_orthonormalize #(
    parameter int FRAC_BITS = cbo_pkg::CBO_FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // fwd_x, fwd_y, fwd_z, up_x, up_y, up_z
    input  wire logic [cbo_pkg::CBO_IN_W-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // side_x, side_y, side_z, nfwd_x, nfwd_y, nfwd_z, nup_x, nup_y, nup_z
    output logic [cbo_pkg::CBO_OUT_W-1:0]        m_axis_tdata,
    // degenerate
    output logic                                 m_axis_tuser
);
    import cbo_pkg::*;

    localparam int VW = 3 * CBO_COMP_W;

    logic       en;
    t_vec3      in_f, in_u;
    t_raw3      f_raw;
    logic       u1_v, u1_zero;
    t_vec3      u1_nf;
    t_vec3      u1_up;
    logic       c1_v;
    t_raw3      c1_raw;
    logic [VW:0] c1_pass;
    logic       u2_v, u2_zero;
    t_vec3      u2_s;
    logic [VW:0] u2_sb;
    logic       c2_v;
    t_raw3      c2_c;
    logic [2*VW:0] c2_pass;
    t_vec3      n_up;

    logic       r_out_v;
    logic [CBO_OUT_W-1:0] r_out_data;
    logic       r_out_deg;

    assign en            = m_axis_tready | ~r_out_v;
    assign s_axis_tready = en;
    assign in_f = s_axis_tdata[VW-1:0];
    assign in_u = s_axis_tdata[2*VW-1:VW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_raw[i] = CBO_RAW_W'($signed(in_f[i]));
        end
    end

    cbo_unit3 #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (VW)
    ) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_c     (f_raw),
        .i_sb    (in_u),
        .o_valid (u1_v),
        .o_u     (u1_nf),
        .o_zero  (u1_zero),
        .o_sb    (u1_up)
    );

    cbo_cross #(
        .PW (VW + 1)
    ) u_side_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (u1_v),
        .i_a     (u1_up),
        .i_b     (u1_nf),
        .i_pass  ({u1_zero, u1_nf}),
        .o_valid (c1_v),
        .o_c     (c1_raw),
        .o_pass  (c1_pass)
    );

    cbo_unit3 #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (VW + 1)
    ) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c1_v),
        .i_c     (c1_raw),
        .i_sb    (c1_pass),
        .o_valid (u2_v),
        .o_u     (u2_s),
        .o_zero  (u2_zero),
        .o_sb    (u2_sb)
    );

    cbo_cross #(
        .PW (2 * VW + 1)
    ) u_up_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (u2_v),
        .i_a     (u2_sb[VW-1:0]),
        .i_b     (u2_s),
        .i_pass  ({u2_zero | u2_sb[VW], u2_s, u2_sb[VW-1:0]}),
        .o_valid (c2_v),
        .o_c     (c2_c),
        .o_pass  (c2_pass)
    );

    always_comb begin
        logic [CBO_RAW_W-1:0] a;
        logic [CBO_RAW_W:0]   sum;
        for (int i = 0; i < 3; i++) begin
            a   = c2_c[i][CBO_RAW_W-1] ? -c2_c[i] : c2_c[i];
            sum = (CBO_RAW_W + 1)'(a) + ((CBO_RAW_W + 1)'(1) << (FRAC_BITS - 1));
            sum = sum >> FRAC_BITS;
            n_up[i] = cbo_sat16(c2_c[i][CBO_RAW_W-1], sum[CBO_RAW_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_deg <= c2_pass[2*VW];
            if (c2_pass[2*VW]) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {n_up, c2_pass[VW-1:0], c2_pass[2*VW-1:VW]};
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_deg;
endmodule
`default_nettype wire

// File: hdl/cbo_cross.sv
// Two-stage pipelined cross product of two Q1 vectors with a carried sideband.
`timescale 1ns / 1ps
`default_nettype none
module cbo_cross #(
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire cbo_pkg::t_vec3 i_a,
    input  wire cbo_pkg::t_vec3 i_b,
    input  wire logic [PW-1:0] i_pass,
    output logic               o_valid,
    output cbo_pkg::t_raw3     o_c,
    output logic [PW-1:0]      o_pass
);
    import cbo_pkg::*;

    localparam int PRW = 2 * CBO_COMP_W;

    logic                  r_v1;
    logic [5:0][PRW-1:0]   r_p;
    logic [PW-1:0]         r_pass1;
    logic                  r_v2;
    t_raw3                 r_c;
    logic [PW-1:0]         r_pass2;
    logic [5:0][PRW-1:0]   n_p;
    t_raw3                 n_c;

    always_comb begin
        n_p[0] = PRW'($signed(i_a[1]) * $signed(i_b[2]));
        n_p[1] = PRW'($signed(i_a[2]) * $signed(i_b[1]));
        n_p[2] = PRW'($signed(i_a[2]) * $signed(i_b[0]));
        n_p[3] = PRW'($signed(i_a[0]) * $signed(i_b[2]));
        n_p[4] = PRW'($signed(i_a[0]) * $signed(i_b[1]));
        n_p[5] = PRW'($signed(i_a[1]) * $signed(i_b[0]));
        for (int i = 0; i < 3; i++) begin
            n_c[i] = CBO_RAW_W'($signed({r_p[2*i][PRW-1], r_p[2*i]})
                                - $signed({r_p[2*i+1][PRW-1], r_p[2*i+1]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= n_p;
            r_pass1 <= i_pass;
            r_c     <= n_c;
            r_pass2 <= r_pass1;
        end
    end

    assign o_valid = r_v2;
    assign o_c     = r_c;
    assign o_pass  = r_pass2;
endmodule
`default_nettype wire

// File: hdl/cbo_isqrt.sv
// Pipelined integer square root, two radicand bits per register stage.
`timescale 1ns / 1ps
`default_nettype none
module cbo_isqrt #(
    parameter int PW = 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [cbo_pkg::CBO_LEN_W-1:0]   i_x,
    input  wire logic [PW-1:0]                   i_pass,
    output logic                                 o_valid,
    output logic [cbo_pkg::CBO_ROOT_W-1:0]       o_root,
    output logic [PW-1:0]                        o_pass
);
    import cbo_pkg::*;

    localparam int XW  = CBO_LEN_W;
    localparam int RTW = CBO_ROOT_W;
    localparam int RMW = RTW + 3;
    localparam int NS  = RTW;

    logic           r_v    [NS];
    logic [XW-1:0]  r_x    [NS];
    logic [RMW-1:0] r_rem  [NS];
    logic [RTW-1:0] r_root [NS];
    logic [PW-1:0]  r_pass [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           v_in;
        logic [XW-1:0]  x_in;
        logic [RMW-1:0] rem_in;
        logic [RTW-1:0] root_in;
        logic [PW-1:0]  p_in;
        logic [RMW-1:0] t;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign p_in    = i_pass;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign p_in    = r_pass[k-1];
        end

        assign t     = {rem_in[RMW-3:0], x_in[XW-1-2*k -: 2]};
        assign trial = RMW'({root_in, 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in;
                r_rem[k]  <= ge ? t - trial : t;
                r_root[k] <= {root_in[RTW-2:0], ge};
                r_pass[k] <= p_in;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_pass  = r_pass[NS-1];
endmodule
`default_nettype wire

// File: hdl/cbo_div.sv
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cbo_div #(
    parameter int NW = 46,
    parameter int DW = 32,
    parameter int QW = 16,
    parameter int PW = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2:0][NW-1:0]    i_num,
    input  wire logic [DW-1:0]         i_den,
    input  wire logic [PW-1:0]         i_pass,
    output logic                       o_valid,
    output logic [2:0][QW-1:0]         o_quo,
    output logic [PW-1:0]              o_pass
);
    localparam int RMW = DW + 1;

    logic                 r_v    [QW];
    logic [2:0][NW-1:0]   r_num  [QW];
    logic [DW-1:0]        r_den  [QW];
    logic [2:0][RMW-1:0]  r_rem  [QW];
    logic [2:0][QW-1:0]   r_quo  [QW];
    logic [PW-1:0]        r_pass [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                v_in;
        logic [2:0][NW-1:0]  num_in;
        logic [DW-1:0]       den_in;
        logic [2:0][RMW-1:0] rem_in;
        logic [2:0][QW-1:0]  quo_in;
        logic [PW-1:0]       p_in;
        logic [2:0][RMW-1:0] n_rem;
        logic [2:0][QW-1:0]  n_quo;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign p_in   = i_pass;
            for (genvar l = 0; l < 3; l++) begin : g_init
                assign rem_in[l] = RMW'(i_num[l][NW-1:QW]);
            end
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign p_in   = r_pass[k-1];
        end

        always_comb begin
            logic [RMW-1:0] t;
            logic           ge;
            for (int l = 0; l < 3; l++) begin
                t  = {rem_in[l][DW-1:0], num_in[l][QW-1-k]};
                ge = (t >= {1'b0, den_in});
                n_rem[l] = ge ? t - {1'b0, den_in} : t;
                n_quo[l] = {quo_in[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= num_in;
                r_den[k]  <= den_in;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_pass[k] <= p_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_pass  = r_pass[QW-1];
endmodule
`default_nettype wire

// File: hdl/cbo_unit3.sv
// Pipelined normaliser that scales a three-component vector to unit length in Q1 format.
`timescale 1ns / 1ps
`default_nettype none
module cbo_unit3 #(
    parameter int FRAC_BITS = cbo_pkg::CBO_FRAC_BITS,
    parameter int SB_W      = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire cbo_pkg::t_raw3  i_c,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output cbo_pkg::t_vec3       o_u,
    output logic                 o_zero,
    output logic [SB_W-1:0]      o_sb
);
    import cbo_pkg::*;

    localparam int QW    = FRAC_BITS + 2;
    localparam int NW    = FRAC_BITS + 32;
    localparam int DW    = CBO_ROOT_W + 1;
    localparam int SQ_PW = 3 * CBO_NORM_W + 4 + SB_W;
    localparam int DV_PW = 4 + SB_W;

    logic                          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [2:0][CBO_MAG_W-1:0]     r1_mag, r2_mag;
    logic [2:0]                    r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;
    logic [CBO_MAG_W-1:0]          r1_or;
    logic [SB_W-1:0]               r1_sb, r2_sb, r3_sb, r4_sb, r5_sb;
    logic [CBO_POS_W-1:0]          r2_pos;
    logic                          r2_zero, r3_zero, r4_zero, r5_zero;
    logic [2:0][CBO_NORM_W-1:0]    r3_m, r4_m, r5_m;
    logic [2:0][CBO_SQ_W-1:0]      r4_sq;
    logic [CBO_LEN_W-1:0]          r5_len;
    logic [2:0][NW-1:0]            r6_num;
    logic [DW-1:0]                 r6_den;
    logic [DV_PW-1:0]              r6_pass;
    t_vec3                         r7_u;
    logic                          r7_zero;
    logic [SB_W-1:0]               r7_sb;

    logic [2:0][CBO_MAG_W-1:0]     n1_mag;
    logic [CBO_POS_W-1:0]          n2_pos;
    logic [2:0][CBO_NORM_W-1:0]    n3_m;
    logic                          sq_v;
    logic [CBO_ROOT_W-1:0]         sq_root;
    logic [SQ_PW-1:0]              sq_pass;
    logic [2:0][CBO_NORM_W-1:0]    sq_m;
    logic [2:0][NW-1:0]            n6_num;
    logic                          dv_v;
    logic [2:0][QW-1:0]            dv_quo;
    logic [DV_PW-1:0]              dv_pass;
    t_vec3                         n7_u;

    always_comb begin
        logic [CBO_RAW_W-1:0] a;
        for (int i = 0; i < 3; i++) begin
            a = i_c[i][CBO_RAW_W-1] ? -i_c[i] : i_c[i];
            n1_mag[i] = a[CBO_MAG_W-1:0];
        end
    end

    always_comb begin
        n2_pos = '0;
        for (int i = 0; i < CBO_MAG_W; i++) begin
            if (r1_or[i]) begin
                n2_pos = CBO_POS_W'(i);
            end
        end
    end

    always_comb begin
        logic [CBO_MAG_W-1:0] s;
        for (int i = 0; i < 3; i++) begin
            if (r2_pos < CBO_POS_W'(CBO_NORM_TOP)) begin
                s = r2_mag[i] << (CBO_POS_W'(CBO_NORM_TOP) - r2_pos);
            end else begin
                s = r2_mag[i] >> (r2_pos - CBO_POS_W'(CBO_NORM_TOP));
            end
            n3_m[i] = s[CBO_NORM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= sq_v;
            r_v7 <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_neg  <= {i_c[2][CBO_RAW_W-1], i_c[1][CBO_RAW_W-1], i_c[0][CBO_RAW_W-1]};
            r1_or   <= n1_mag[0] | n1_mag[1] | n1_mag[2];
            r1_sb   <= i_sb;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_pos  <= n2_pos;
            r2_zero <= (r1_or == '0);
            r2_sb   <= r1_sb;
            r3_m    <= n3_m;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_sb   <= r2_sb;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= CBO_SQ_W'(r3_m[i] * r3_m[i]);
            end
            r4_m    <= r3_m;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r4_sb   <= r3_sb;
            r5_len  <= CBO_LEN_W'(r4_sq[0]) + CBO_LEN_W'(r4_sq[1]) + CBO_LEN_W'(r4_sq[2]);
            r5_m    <= r4_m;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
            r5_sb   <= r4_sb;
        end
    end

    cbo_isqrt #(
        .PW (SQ_PW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v5),
        .i_x     (r5_len),
        .i_pass  ({r5_sb, r5_zero, r5_neg, r5_m}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_pass  (sq_pass)
    );

    assign sq_m = sq_pass[3*CBO_NORM_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_num[i] = NW'({sq_m[i], {(FRAC_BITS + 1){1'b0}}}) + NW'(sq_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_num  <= n6_num;
            r6_den  <= {sq_root, 1'b0};
            r6_pass <= sq_pass[SQ_PW-1:3*CBO_NORM_W];
        end
    end

    cbo_div #(
        .NW (NW),
        .DW (DW),
        .QW (QW),
        .PW (DV_PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v6),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_pass  (r6_pass),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_pass  (dv_pass)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_pass[3]) begin
                n7_u[i] = '0;
            end else begin
                n7_u[i] = cbo_sat16(dv_pass[i], CBO_RAW_W'(dv_quo[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_u    <= n7_u;
            r7_zero <= dv_pass[3];
            r7_sb   <= dv_pass[DV_PW-1:4];
        end
    end

    assign o_valid = r_v7;
    assign o_u     = r7_u;
    assign o_zero  = r7_zero;
    assign o_sb    = r7_sb;
endmodule
`default_nettype wire

// File: hdl/cbo_checker.sv
// Port-level checker for the camera basis orthonormaliser and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module cbo_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [95:0]  s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [143:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off with no result waiting");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate item carries non-zero vectors");

    a_forward_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:48] != '0)
        else $error("valid basis with zero forward vector");
endmodule

bind camera_basis_orthonormalize cbo_checker u_cbo_checker (.*);
`default_nettype wire

// File: dv/tb_camera_basis_orthonormalize.sv
// Testbench of the camera basis orthonormaliser: directed and random vectors against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_camera_basis_orthonormalize;
    import cbo_pkg::*;

    localparam int FB = CBO_FRAC_BITS;
    localparam int LATENCY = 2 * FB + 85;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CBO_OUT_W-1:0] vecs;
        logic                 degen;
    } t_basis;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [CBO_IN_W-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [CBO_OUT_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    t_basis expected_bases[$];
    int     error_count;
    int     idle_cycles;
    int     send_gap_pct;
    int     recv_stall_pct;
    bit     hold_receiver;
    int     hold_cycles;

    camera_basis_orthonormalize uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_component(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Returns 0 when the vector has zero length.
    function automatic bit unit_vector(input longint c[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned big, len2, root, q;
        big = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > big) big = m[i];
            o[i] = 0;
        end
        if (big == 0) return 1'b0;
        while (big < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            big <<= 1;
        end
        while (big >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            big >>= 1;
        end
        for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
        root = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << (FB + 1)) + root) / (2 * root);
            o[i] = sat_component(c[i] < 0 ? -longint'(q) : longint'(q));
        end
        return 1'b1;
    endfunction

    function automatic longint round_frac(input longint v);
        longint unsigned q;
        q = ((v < 0 ? -v : v) + (64'd1 << (FB - 1))) >> FB;
        return sat_component(v < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_basis predict_basis(input logic [CBO_IN_W-1:0] item);
        longint f[3], u[3], nf[3], raw[3], s[3], nu[3];
        bit ok;
        t_basis b;
        for (int i = 0; i < 3; i++) begin
            f[i] = longint'($signed(item[16*i +: 16]));
            u[i] = longint'($signed(item[16*(i+3) +: 16]));
            s[i] = 0;
            nu[i] = 0;
        end
        ok = unit_vector(f, nf);
        if (ok) begin
            raw[0] = u[1] * nf[2] - u[2] * nf[1];
            raw[1] = u[2] * nf[0] - u[0] * nf[2];
            raw[2] = u[0] * nf[1] - u[1] * nf[0];
            ok = unit_vector(raw, s);
        end
        if (ok) begin
            nu[0] = round_frac(nf[1] * s[2] - nf[2] * s[1]);
            nu[1] = round_frac(nf[2] * s[0] - nf[0] * s[2]);
            nu[2] = round_frac(nf[0] * s[1] - nf[1] * s[0]);
        end else begin
            for (int i = 0; i < 3; i++) begin
                nf[i] = 0;
                s[i] = 0;
                nu[i] = 0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            b.vecs[16*i +: 16] = s[i][15:0];
            b.vecs[16*(i+3) +: 16] = nf[i][15:0];
            b.vecs[16*(i+6) +: 16] = nu[i][15:0];
        end
        b.degen = !ok;
        return b;
    endfunction

    task automatic send_item(input logic [15:0] fx, fy, fz, ux, uy, uz);
        logic [CBO_IN_W-1:0] item;
        item = {uz, uy, ux, fz, fy, fx};
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_bases.push_back(predict_basis(item));
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_component();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_bases.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_item(16'h4000, 0, 0, 0, 16'h4000, 0);
        send_item(0, 0, 16'hc000, 0, 16'h4000, 0);
        send_item(0, 0, 0, 0, 16'h4000, 0);
        send_item(16'h4000, 0, 0, 0, 0, 0);
        send_item(16'h4000, 0, 0, 16'h2000, 0, 0);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_item(16'h8000, 0, 0, 0, 16'h8000, 0);
        send_item(16'h0001, 0, 0, 0, 0, 16'h0001);
        send_item(16'hffff, 16'h0001, 0, 16'h0001, 16'hffff, 0);
        send_item(16'h0001, 16'h0002, 16'h0003, 16'h0002, 16'h0004, 16'h0006);
        send_item(16'h7fff, 16'h8000, 16'h0001, 16'h0001, 16'hffff, 16'h7fff);
        send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(16'h1234, 16'hedcb, 16'h0f0f, 16'h5555, 16'haaaa, 16'h00ff);
    endtask

    task automatic test_random(input int count);
        logic [15:0] f[3];
        int k;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) f[i] = rand_component();
            k = $urandom_range(9);
            if (k == 0) begin
                send_item(f[0], f[1], f[2], f[0], f[1], f[2]);
            end else if (k == 1) begin
                send_item(f[0], f[1], f[2], -f[0], -f[1], -f[2]);
            end else begin
                send_item(f[0], f[1], f[2], rand_component(), rand_component(),
                          rand_component());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        hold_receiver = 1'b1;
        test_random(200);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        t_basis want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bases.size() == 0) begin
                $display("%0t: unexpected result data=%h degenerate=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_bases.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (m_axis_tdata[16*i +: 16] !== want.vecs[16*i +: 16]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, i,
                                 want.vecs[16*i +: 16], m_axis_tdata[16*i +: 16]);
                        error_count++;
                    end
                end
                if (m_axis_tuser !== want.degen) begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             want.degen, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_receiver) begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
            if (hold_cycles <= 0) hold_receiver = 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || hold_receiver || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_camera_basis_orthonormalize: errors");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        hold_receiver = 1'b0;
        hold_cycles = 0;
        send_gap_pct = 10;
        recv_stall_pct = 56;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150);
        wait_drained();
        send_gap_pct = 56;
        recv_stall_pct = 10;
        test_random(150);
        test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(200);
        wait_drained();
        repeat (LATENCY + 20) @(negedge i_clk);
        if (error_count == 0 && expected_bases.size() == 0) begin
            $display("tb_camera_basis_orthonormalize: clean");
        end else begin
            $display("tb_camera_basis_orthonormalize: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
